@@ design/kcl_pkg.sv @@
// Shared types and codes for the keyed circular list engine.
// No dependencies; imported by kcl_node_mem and keyed_circular_list_engine.
package kcl_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  // request commands
  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_DELETE = 2'd1;
  localparam cmd_t CMD_LOOKUP = 2'd2;
  localparam cmd_t CMD_CLEAR  = 2'd3;

  // result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_PRESENT   = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  // node memory strobes
  typedef struct packed {
    logic rd_en;
    logic data_we;
    logic link_we;
  } mem_ctl_t;

endpackage

@@ design/kcl_node_mem.sv @@
// Node memory of the keyed circular list engine: key, value and link arrays.
// One write address and one read address per cycle, read data registered.
// Depends on kcl_pkg.
module kcl_node_mem #(
  parameter int CAPACITY = 64
) (
  input  logic                                        clk,
  input  kcl_pkg::mem_ctl_t                           ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]               rd_addr,
  input  logic [$clog2(CAPACITY+1)-1:0]               wr_addr,
  input  logic [kcl_pkg::KEY_W-1:0]                   wr_key,
  input  logic [kcl_pkg::VALUE_W-1:0]                 wr_value,
  input  logic [$clog2(CAPACITY+1)-1:0]               wr_link,
  output logic [kcl_pkg::KEY_W-1:0]                   rd_key,
  output logic [kcl_pkg::VALUE_W-1:0]                 rd_value,
  output logic [$clog2(CAPACITY+1)-1:0]               rd_link
);
  import kcl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  logic [KEY_W-1:0]   key_mem   [CAPACITY];
  logic [VALUE_W-1:0] value_mem [CAPACITY];
  logic [LW-1:0]      link_mem  [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.data_we) begin
      key_mem[wr_addr[AW-1:0]]   <= wr_key;
      value_mem[wr_addr[AW-1:0]] <= wr_value;
    end
    if (ctl.link_we) begin
      link_mem[wr_addr[AW-1:0]] <= wr_link;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_key   <= key_mem[rd_addr[AW-1:0]];
      rd_value <= value_mem[rd_addr[AW-1:0]];
      rd_link  <= link_mem[rd_addr[AW-1:0]];
    end
  end

endmodule

@@ design/keyed_circular_list_engine.sv @@
// Keyed circular list engine: bounded key-value store kept as a circular
// linked list with a sentinel. Depends on kcl_pkg and kcl_node_mem.
//
// Usage
// - Input channel (in_valid/in_stall): one request of command, key, value.
//   Commands are insert, delete, lookup and clear.
// - Result channel (out_valid/out_stall): one result per request with a
//   status, the found value (lookup only) and the entry count afterwards.
// - A request walks the list one node per cycle through the node memory
//   read port, then a decide step; clear skips both. An insert that
//   allocates adds a node write and a tail link write, behind a free-chain
//   read when it reuses a freed slot; a delete that unlinks adds an unlink
//   and a free-chain write. A request is worked on alone: the next one is
//   taken only once the engine is back in idle.
// - The result sits in an output register; the next request may be taken
//   while it waits. If the receiver stalls and a further result is ready,
//   the engine holds in its final state until the register frees.
// - Reset (rst_n low, synchronous) empties the list at once: unallocated
//   slots are tracked by a fill mark, so there is no clearing pass.
module keyed_circular_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  kcl_pkg::cmd_t                       in_command,
  input  logic signed [kcl_pkg::KEY_W-1:0]    in_key,
  input  logic signed [kcl_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output kcl_pkg::status_t                    out_status,
  output logic signed [kcl_pkg::VALUE_W-1:0]  out_found_value,
  output logic [kcl_pkg::COUNT_W-1:0]         out_entry_count
);
  import kcl_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] SENT = LW'(CAPACITY);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_WALK       = 4'd1;
  localparam logic [3:0] S_DECIDE     = 4'd2;
  localparam logic [3:0] S_FREE_RD    = 4'd3;
  localparam logic [3:0] S_INS_NODE   = 4'd4;
  localparam logic [3:0] S_INS_LINK   = 4'd5;
  localparam logic [3:0] S_DEL_UNLINK = 4'd6;
  localparam logic [3:0] S_DEL_FREE   = 4'd7;
  localparam logic [3:0] S_DONE       = 4'd8;

  // control state
  logic [3:0]    state_r, state_nxt;
  logic [LW-1:0] first_r, first_nxt;
  logic [LW-1:0] last_r, last_nxt;
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  // request payload and walk state
  cmd_t                cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [LW-1:0]       cur_r, cur_nxt;
  logic [LW-1:0]       prev_r, prev_nxt;
  logic [LW-1:0]       steps_r, steps_nxt;
  logic                hit_r, hit_nxt;
  logic [LW-1:0]       hit_next_r, hit_next_nxt;
  logic [VALUE_W-1:0]  found_r, found_nxt;
  logic [LW-1:0]       slot_r, slot_nxt;
  status_t             res_status_r, res_status_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]  out_found_r, out_found_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  // memory interface
  mem_ctl_t            mem_ctl;
  logic [LW-1:0]       rd_addr, wr_addr, wr_link;
  logic [KEY_W-1:0]    rd_key;
  logic [VALUE_W-1:0]  rd_value;
  logic [LW-1:0]       rd_link;
  logic                accept;
  logic                out_free;

  kcl_node_mem #(
    .CAPACITY (CAPACITY)
  ) u_mem (
    .clk      (clk),
    .ctl      (mem_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_key   (key_r),
    .wr_value (val_r),
    .wr_link  (wr_link),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .rd_link  (rd_link)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    free_head_nxt  = free_head_r;
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    steps_nxt      = steps_r;
    hit_nxt        = hit_r;
    hit_next_nxt   = hit_next_r;
    found_nxt      = found_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    mem_ctl        = '0;
    rd_addr        = first_r;
    wr_addr        = slot_r;
    wr_link        = SENT;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_command;
          key_nxt        = in_key;
          val_nxt        = in_value;
          hit_nxt        = 1'b0;
          found_nxt      = '0;
          prev_nxt       = SENT;
          cur_nxt        = first_r;
          steps_nxt      = LW'(1);
          res_status_nxt = ST_OK;
          if (in_command == CMD_CLEAR) begin
            first_nxt     = SENT;
            last_nxt      = SENT;
            free_head_nxt = '0;
            fill_nxt      = '0;
            cnt_nxt       = '0;
            state_nxt     = S_DONE;
          end else if (first_r >= SENT) begin
            state_nxt = S_DECIDE;
          end else begin
            mem_ctl.rd_en = 1'b1;
            state_nxt     = S_WALK;
          end
        end
      end

      // one node per cycle: compare, then follow the link
      S_WALK: begin
        rd_addr = rd_link;
        if (rd_key == key_r) begin
          hit_nxt      = 1'b1;
          hit_next_nxt = rd_link;
          found_nxt    = rd_value;
          state_nxt    = S_DECIDE;
        end else if (rd_link >= SENT || steps_r == SENT) begin
          prev_nxt  = cur_r;
          state_nxt = S_DECIDE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          prev_nxt      = cur_r;
          cur_nxt       = rd_link;
          steps_nxt     = steps_r + LW'(1);
        end
      end

      S_DECIDE: begin
        rd_addr   = free_head_r;
        state_nxt = S_DONE;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (hit_r) begin
              res_status_nxt = ST_PRESENT;
            end else if (free_head_r >= SENT) begin
              res_status_nxt = ST_FULL;
            end else begin
              slot_nxt = free_head_r;
              if (free_head_r < fill_r) begin
                // recycled slot: its link holds the next free slot
                mem_ctl.rd_en = 1'b1;
                state_nxt     = S_FREE_RD;
              end else begin
                // fresh slot at the fill mark
                free_head_nxt = free_head_r + LW'(1);
                fill_nxt      = fill_r + LW'(1);
                state_nxt     = S_INS_NODE;
              end
            end
          end
          CMD_DELETE: begin
            if (hit_r) begin
              state_nxt = S_DEL_UNLINK;
            end else begin
              res_status_nxt = ST_NOT_FOUND;
            end
          end
          CMD_LOOKUP: begin
            if (!hit_r) begin
              res_status_nxt = ST_NOT_FOUND;
            end
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end

      S_FREE_RD: begin
        free_head_nxt = rd_link;
        state_nxt     = S_INS_NODE;
      end

      // new tail node points at the sentinel
      S_INS_NODE: begin
        mem_ctl.data_we = 1'b1;
        mem_ctl.link_we = 1'b1;
        wr_addr         = slot_r;
        wr_link         = SENT;
        state_nxt       = S_INS_LINK;
      end

      S_INS_LINK: begin
        wr_addr = last_r;
        wr_link = slot_r;
        if (last_r >= SENT) begin
          first_nxt = slot_r;
        end else begin
          mem_ctl.link_we = 1'b1;
        end
        last_nxt  = slot_r;
        cnt_nxt   = cnt_r + LW'(1);
        state_nxt = S_DONE;
      end

      // bypass the hit node; the count drops in the same step as the unlink
      S_DEL_UNLINK: begin
        wr_addr = prev_r;
        wr_link = hit_next_r;
        if (prev_r >= SENT) begin
          first_nxt = hit_next_r;
        end else begin
          mem_ctl.link_we = 1'b1;
        end
        if (last_r == cur_r) begin
          last_nxt = prev_r;
        end
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - LW'(1);
        end
        state_nxt = S_DEL_FREE;
      end

      // push the node onto the free chain
      S_DEL_FREE: begin
        mem_ctl.link_we = 1'b1;
        wr_addr         = cur_r;
        wr_link         = free_head_r;
        free_head_nxt   = cur_r;
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = (cmd_r == CMD_LOOKUP && hit_r) ? found_r : '0;
          out_count_nxt  = COUNT_W'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= SENT;
      last_r      <= SENT;
      free_head_r <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    steps_r      <= steps_nxt;
    hit_r        <= hit_nxt;
    hit_next_r   <= hit_next_nxt;
    found_r      <= found_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;
  assign out_entry_count = out_count_r;

  // entries never exceed the slots handed out below the fill mark
  a_cnt_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= fill_r)
    else $error("entry count above fill mark");

  // free chain head is a recycled slot or the fill mark
  a_free_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= fill_r)
    else $error("free head beyond fill mark");

  // empty list and sentinel head go together
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (first_r == SENT) == (cnt_r == '0))
    else $error("list head disagrees with entry count");

  // a clear request empties the store at once
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_CLEAR) |=> (cnt_r == '0 && fill_r == '0))
    else $error("clear did not empty the store");

endmodule

@@ bench/kcl_list_checker.sv @@
// Result checker for the keyed circular list engine: mirrors the linked list,
// predicts every result and compares it with what leaves the block.
// Depends on kcl_pkg.
module kcl_list_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  kcl_pkg::cmd_t                       in_command,
  input  logic signed [kcl_pkg::KEY_W-1:0]    in_key,
  input  logic signed [kcl_pkg::VALUE_W-1:0]  in_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  kcl_pkg::status_t                    out_status,
  input  logic signed [kcl_pkg::VALUE_W-1:0]  out_found_value,
  input  logic [kcl_pkg::COUNT_W-1:0]         out_entry_count,
  output int                                  fail_count,
  output int                                  results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import kcl_pkg::*;

  // the sentinel doubles as the null link
  localparam int NIL = CAPACITY;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   found_value;
    logic [COUNT_W-1:0]   entry_count;
  } list_result_t;

  // mirrored list
  logic [KEY_W-1:0]   slot_key   [CAPACITY];
  logic [VALUE_W-1:0] slot_value [CAPACITY];
  int                 slot_next  [CAPACITY];
  int                 head_slot;
  int                 tail_slot;
  int                 free_slot;
  int                 live_entries;

  list_result_t expected_results [$];

  // empty list, free chain in index order
  function automatic void empty_list();
    for (int i = 0; i < CAPACITY; i++) slot_next[i] = i + 1;
    head_slot = NIL;
    tail_slot = NIL;
    free_slot = 0;
    live_entries = 0;
  endfunction

  function automatic list_result_t apply_request(cmd_t cmd, logic [KEY_W-1:0] key,
                                                 logic [VALUE_W-1:0] value);
    list_result_t res;
    int prev;
    int cur;
    int steps;
    int hit;
    int slot;
    res.status = ST_OK;
    res.found_value = '0;
    prev = NIL;
    cur = head_slot;
    steps = 0;
    hit = NIL;
    if (cmd == CMD_CLEAR) begin
      empty_list();
    end else begin
      // walk from the head, stopping at the first match or after a full lap
      while (hit == NIL && cur < NIL && steps < CAPACITY) begin
        if (slot_key[cur] == key) begin
          hit = cur;
        end else begin
          prev = cur;
          cur = slot_next[cur];
          steps++;
        end
      end
      case (cmd)
        CMD_INSERT: begin
          // a present key wins over a full store
          if (hit != NIL) begin
            res.status = ST_PRESENT;
          end else if (free_slot >= NIL) begin
            res.status = ST_FULL;
          end else begin
            slot = free_slot;
            free_slot = slot_next[slot];
            slot_key[slot] = key;
            slot_value[slot] = value;
            slot_next[slot] = NIL;
            if (tail_slot >= NIL) head_slot = slot;
            else slot_next[tail_slot] = slot;
            tail_slot = slot;
            live_entries++;
          end
        end
        CMD_DELETE: begin
          if (hit == NIL) begin
            res.status = ST_NOT_FOUND;
          end else begin
            // unlink and return the slot to the head of the free chain
            if (prev >= NIL) head_slot = slot_next[hit];
            else slot_next[prev] = slot_next[hit];
            if (tail_slot == hit) tail_slot = prev;
            slot_next[hit] = free_slot;
            free_slot = hit;
            if (live_entries > 0) live_entries--;
          end
        end
        default: begin
          if (hit == NIL) res.status = ST_NOT_FOUND;
          else res.found_value = slot_value[hit];
        end
      endcase
    end
    res.entry_count = COUNT_W'(live_entries);
    return res;
  endfunction

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst_n) begin
      empty_list();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(apply_request(in_command, in_key, in_value));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d, found_value %0d",
                 out_status, out_found_value);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, out_status);
            fail_count++;
          end
          if (out_found_value !== exp_res.found_value) begin
            $error("found_value: expected %0d, actual %0d",
                   $signed(exp_res.found_value), out_found_value);
            fail_count++;
          end
          if (out_entry_count !== exp_res.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   exp_res.entry_count, out_entry_count);
            fail_count++;
          end
        end
      end
    end
    results_outstanding = expected_results.size();
  end

endmodule

@@ bench/keyed_circular_list_engine_tb.sv @@
// Top of the keyed circular list engine bench: clock, reset, request stimulus
// and result-side stalls. Depends on kcl_pkg, the engine and kcl_list_checker.
module keyed_circular_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kcl_pkg::*;

  localparam int CAPACITY         = 64;
  localparam int POOL_SIZE        = 80;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int DRAIN_LIMIT      = 20000;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  cmd_t                      in_command = CMD_LOOKUP;
  logic signed [KEY_W-1:0]   in_key = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  status_t                   out_status;
  logic signed [VALUE_W-1:0] out_found_value;
  logic [COUNT_W-1:0]        out_entry_count;
  int                        fail_count;
  int                        results_outstanding;

  int                send_idle_pct = 36;
  int                recv_idle_pct = 74;
  int                fill_cursor = 0;
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  keyed_circular_list_engine #(.CAPACITY(CAPACITY)) dut (.*);

  kcl_list_checker #(.CAPACITY(CAPACITY)) list_check (.*);

  always #10 clk = ~clk;

  // result-side stalls
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  // hard stop
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // one request, with random idle cycles ahead of it
  task automatic send_request(cmd_t cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_key     <= key;
    in_value   <= value;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 24))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // bursts of fills, drains and mixed traffic over a pool of keys
  task automatic run_random(int item_total);
    burst_kind_t      kind;
    int               left;
    int               len;
    int               roll;
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    left = item_total;
    kind = BURST_FILL;
    while (left > 0) begin
      len = (kind == BURST_FILL) ? $urandom_range(70, 110) : $urandom_range(10, 50);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        roll = $urandom_range(0, 99);
        case (kind)
          BURST_FILL:
            cmd = (roll < 80) ? CMD_INSERT : (roll < 92) ? CMD_LOOKUP : CMD_DELETE;
          BURST_DRAIN:
            cmd = (roll < 62) ? CMD_DELETE : (roll < 86) ? CMD_LOOKUP : CMD_INSERT;
          default:
            cmd = (roll < 4) ? CMD_CLEAR : (roll < 36) ? CMD_INSERT :
                  (roll < 60) ? CMD_DELETE : CMD_LOOKUP;
        endcase
        // fills take pool keys in turn so the store reaches capacity
        if (kind == BURST_FILL && cmd == CMD_INSERT && $urandom_range(0, 9) != 0) begin
          key = key_pool[fill_cursor];
          fill_cursor = (fill_cursor + 1) % POOL_SIZE;
        end else begin
          key = pick_key();
        end
        send_request(cmd, key, pick_value());
      end
      left -= len;
      kind = burst_kind_t'($urandom_range(0, 2));
    end
  endtask

  initial begin
    int waited;
    // key pool with the extremes up front
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, extremes, duplicates, head/middle/tail unlink, clear
    send_request(CMD_LOOKUP, key_pool[0], 32'h1234_5678);
    send_request(CMD_DELETE, key_pool[0], 32'h0);
    send_request(CMD_INSERT, key_pool[0], 32'h7FFF_FFFF);
    send_request(CMD_INSERT, key_pool[1], 32'h8000_0000);
    send_request(CMD_INSERT, key_pool[2], 32'h0000_0000);
    send_request(CMD_INSERT, key_pool[3], 32'hFFFF_FFFF);
    send_request(CMD_INSERT, key_pool[0], 32'h5A5A_5A5A);
    send_request(CMD_LOOKUP, key_pool[0], 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, key_pool[3], 32'h0);
    send_request(CMD_LOOKUP, key_pool[4], 32'h0);
    send_request(CMD_DELETE, key_pool[2], 32'h0);
    send_request(CMD_DELETE, key_pool[0], 32'h0);
    send_request(CMD_DELETE, key_pool[3], 32'h0);
    send_request(CMD_LOOKUP, key_pool[1], 32'h0);
    send_request(CMD_INSERT, key_pool[2], 32'h5555_5555);
    send_request(CMD_INSERT, key_pool[4], 32'hAAAA_AAAA);
    send_request(CMD_LOOKUP, key_pool[4], 32'h0);
    send_request(CMD_DELETE, key_pool[1], 32'h0);
    send_request(CMD_DELETE, key_pool[4], 32'h0);
    send_request(CMD_CLEAR, key_pool[2], 32'h0);
    send_request(CMD_LOOKUP, key_pool[2], 32'h0);
    send_request(CMD_CLEAR, key_pool[0], 32'hFFFF_FFFF);
    send_request(CMD_INSERT, key_pool[5], $urandom);
    send_request(CMD_LOOKUP, key_pool[5], 32'h0);

    // random traffic under three idling regimes
    run_random(RANDOM_PER_PHASE);
    send_idle_pct = 74;
    recv_idle_pct = 36;
    run_random(RANDOM_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);
    in_valid <= 1'b0;

    // drain outstanding results, then let the engine settle
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (results_outstanding != 0 && waited < DRAIN_LIMIT);
    repeat (CAPACITY + 8) @(posedge clk);

    if (results_outstanding != 0)
      $error("%0d expected results never arrived", results_outstanding);
    if (fail_count == 0 && results_outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
